// ===== rtl/core/pct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the periodic compare timer
// Register map codes, field widths and the configuration bundle that the
// register block hands to the timer datapath.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int CHANNELS      = 4;
    localparam int COUNT_BITS    = 16;
    localparam int PRESCALE_BITS = 16;
    localparam int PERIOD_BITS   = 16;

    // APB register file
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_PRESCALE = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_PERIOD0  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ENABLE   = 3'd5;

    localparam logic [PERIOD_BITS-1:0]   PERIOD_RESET   = 16'hffff;
    localparam logic [PRESCALE_BITS-1:0] PRESCALE_RESET = '0;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_BITS = 8;
    localparam int M_DATA_BITS = 24;

    typedef struct packed {
        logic [PRESCALE_BITS-1:0]                prescale_limit;
        logic [CHANNELS-1:0][PERIOD_BITS-1:0]    period;
        logic [CHANNELS-1:0]                     enable;
    } cfg_t;

endpackage : pct_pkg
`default_nettype wire

// ===== rtl/core/periodic_compare_timer_four_channel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_compare_timer_four_channel: prescaled 16-bit timer, four compares
//
//   channel  dir  payload                                    handshake
//   s_       in   tdata[0] tick, tdata[1] restart            tvalid/tready
//   m_       out  tdata[3:0] fire_mask, [19:4] count_value   tvalid/tready
//   apb      in   prescale, period0..3, enable at 4*i        psel/penable
//
// One item per cycle sustained while m_tready stays high; an item passes the input register, then
// the compare/advance logic into the result register.
// The counter, prescaler and match points update in the same edge that
// loads the result register, so consecutive items see each other's state.
// Reset (aresetn low, synchronous) clears counters, loads match points
// with 0xffff and restores the register defaults.
// A stalled output holds the result; one more item waits in the input stage.
// ----------------------------------------------------------------------------
module periodic_compare_timer_four_channel (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // tick (bit 0), restart (bit 1), zero padding
    input  wire logic [pct_pkg::S_DATA_BITS-1:0] s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // fire_mask (bits 3:0), count_value (bits 19:4), zero padding
    output logic      [pct_pkg::M_DATA_BITS-1:0] m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pct_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [pct_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [pct_pkg::DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import pct_pkg::*;

    cfg_t cfg;

    logic                     in_vld_reg, in_vld_next;
    logic                     in_tick_reg;
    logic                     in_restart_reg;
    logic                     out_vld_reg, out_vld_next;
    logic [CHANNELS-1:0]      out_fire_reg;
    logic [COUNT_BITS-1:0]    out_count_reg;
    logic [PRESCALE_BITS-1:0] pcount_reg, pcount_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next, count_inc;
    logic [CHANNELS-1:0][COUNT_BITS-1:0] match_reg, match_next;
    logic [CHANNELS-1:0]      fire_next;
    logic                     out_free;
    logic                     step;
    logic                     advance;
    logic                     s_accept;

    pct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign in_vld_next  = s_accept ? 1'b1 : (step ? 1'b0 : in_vld_reg);
    assign out_vld_next = step ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    // a prescaler count above a lowered limit counts as reaching it
    assign advance   = in_tick_reg && !in_restart_reg && (pcount_reg >= cfg.prescale_limit);
    assign count_inc = count_reg + COUNT_BITS'(1);

    always_comb begin
        pcount_next = pcount_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        fire_next   = '0;
        if (in_restart_reg) begin
            pcount_next = '0;
            count_next  = '0;
            for (int k = 0; k < CHANNELS; k++) begin
                match_next[k] = COUNT_BITS'(cfg.period[k]);
            end
        end else if (advance) begin
            pcount_next = '0;
            count_next  = count_inc;
            for (int k = 0; k < CHANNELS; k++) begin
                if (cfg.enable[k] && (match_reg[k] == count_inc)) begin
                    fire_next[k]  = 1'b1;
                    match_next[k] = match_reg[k] + COUNT_BITS'(cfg.period[k]);
                end
            end
        end else if (in_tick_reg) begin
            pcount_next = pcount_reg + PRESCALE_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pcount_reg  <= '0;
            count_reg   <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                match_reg[k] <= COUNT_BITS'(PERIOD_RESET);
            end
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (step) begin
                pcount_reg <= pcount_next;
                count_reg  <= count_next;
                match_reg  <= match_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_tick_reg    <= s_tdata[0];
            in_restart_reg <= s_tdata[1];
        end
        if (step) begin
            out_fire_reg  <= fire_next;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DATA_BITS'({out_count_reg, out_fire_reg});

`ifndef NO_ASSERTIONS
    a_restart_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_restart_reg |=> out_fire_reg == '0 && out_count_reg == '0)
        else $error("restart item produced a fire or nonzero count");

    a_fire_needs_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !advance |=> out_fire_reg == '0)
        else $error("channel fired without a counter advance");

    a_fire_enabled_only: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> (fire_next & ~cfg.enable) == '0)
        else $error("disabled channel fired");

    a_advance_increments: assert property (@(posedge aclk) disable iff (!aresetn)
        step && advance |=> out_count_reg == COUNT_BITS'($past(count_reg) + 1'b1))
        else $error("counter did not step by one on advance");
`endif

endmodule : periodic_compare_timer_four_channel
`default_nettype wire

// ===== rtl/core/pct_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pct_regs: APB configuration registers
// Prescale limit, one period per channel and the channel enable mask.
// Writes land on the access cycle; reads return the stored value.
// ----------------------------------------------------------------------------
module pct_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pct_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [pct_pkg::DATA_BITS-1:0] pwdata,
    output logic      [pct_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    output pct_pkg::cfg_t                      cfg
);
    import pct_pkg::*;

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic                wr_en;
    logic [IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PRESCALE: cfg_next.prescale_limit = pwdata[PRESCALE_BITS-1:0];
                REG_ENABLE:   cfg_next.enable         = pwdata[CHANNELS-1:0];
                default: begin
                    // period registers; unmapped indexes fall through untouched
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (reg_idx == REG_PERIOD0 + IDX_BITS'(k)) begin
                            cfg_next.period[k] = pwdata[PERIOD_BITS-1:0];
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_PRESCALE: prdata = DATA_BITS'(cfg_reg.prescale_limit);
            REG_ENABLE:   prdata = DATA_BITS'(cfg_reg.enable);
            default: begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (reg_idx == REG_PERIOD0 + IDX_BITS'(k)) begin
                        prdata = DATA_BITS'(cfg_reg.period[k]);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prescale_limit <= PRESCALE_RESET;
            cfg_reg.enable         <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                cfg_reg.period[k] <= PERIOD_RESET;
            end
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : pct_regs
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the four-channel periodic compare timer
// Streams tick, restart and idle items into the timer under random gaps and
// back-pressure, programs the APB registers between phases and reads them
// back. A scoreboard class tracks prescaler, counter and match points and
// compares every result item field by field.
// ----------------------------------------------------------------------------
module tb;
    import pct_pkg::*;

    localparam logic [IDX_BITS-1:0] REG_SPARE = 3'd6;
    localparam int LATENCY   = 2;
    localparam int HOLD_LONG = 300;

    typedef struct {
        logic [CHANNELS-1:0]   fire;
        logic [COUNT_BITS-1:0] count;
    } timer_result_t;

    class timer_scoreboard;
        logic [PRESCALE_BITS-1:0] prescale_limit;
        logic [PERIOD_BITS-1:0]   period [CHANNELS];
        logic [CHANNELS-1:0]      enable;
        logic [PRESCALE_BITS-1:0] prescale_cnt;
        logic [COUNT_BITS-1:0]    main_cnt;
        logic [COUNT_BITS-1:0]    match_pt [CHANNELS];
        timer_result_t            timer_results_q[$];
        int                       errors;
        int                       printed;

        function new();
            prescale_limit = PRESCALE_RESET;
            enable         = '0;
            prescale_cnt   = '0;
            main_cnt       = '0;
            for (int k = 0; k < CHANNELS; k++) begin
                period[k]   = PERIOD_RESET;
                match_pt[k] = PERIOD_RESET;
            end
            errors  = 0;
            printed = 0;
        endfunction

        function void set_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
            if (idx == REG_PRESCALE) begin
                prescale_limit = val[PRESCALE_BITS-1:0];
            end else if (idx >= REG_PERIOD0 && idx < REG_PERIOD0 + CHANNELS) begin
                period[idx - REG_PERIOD0] = val[PERIOD_BITS-1:0];
            end else if (idx == REG_ENABLE) begin
                enable = val[CHANNELS-1:0];
            end
        endfunction

        // advance the timer by one accepted item and queue its result
        function void note_input(bit tick, bit restart);
            timer_result_t res;
            res.fire = '0;
            if (restart) begin
                prescale_cnt = '0;
                main_cnt     = '0;
                for (int k = 0; k < CHANNELS; k++) match_pt[k] = period[k];
            end else if (tick) begin
                // a count above a lowered limit counts as reaching it
                if (prescale_cnt >= prescale_limit) begin
                    prescale_cnt = '0;
                    main_cnt     = main_cnt + 1'b1;
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (enable[k] && match_pt[k] == main_cnt) begin
                            res.fire[k] = 1'b1;
                            match_pt[k] = match_pt[k] + period[k];
                        end
                    end
                end else begin
                    prescale_cnt = prescale_cnt + 1'b1;
                end
            end
            res.count = main_cnt;
            timer_results_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (printed < 20) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
                printed++;
            end
        endtask

        task check_result(logic [M_DATA_BITS-1:0] data);
            timer_result_t exp_res;
            if (timer_results_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", data));
            end else begin
                exp_res = timer_results_q.pop_front();
                if (data[CHANNELS-1:0] !== exp_res.fire)
                    report_mismatch($sformatf("fire_mask %h, expected %h",
                                              data[CHANNELS-1:0], exp_res.fire));
                if (data[CHANNELS +: COUNT_BITS] !== exp_res.count)
                    report_mismatch($sformatf("count_value %h, expected %h",
                                              data[CHANNELS +: COUNT_BITS], exp_res.count));
                if (data[M_DATA_BITS-1:CHANNELS+COUNT_BITS] !== '0)
                    report_mismatch($sformatf("nonzero padding in result %h", data));
            end
        endtask

        function int pending();
            return timer_results_q.size();
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]   paddr    = '0;
    logic [DATA_BITS-1:0]   pwdata   = '0;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_hold_req = 1'b0;

    timer_scoreboard sb;

    periodic_compare_timer_four_channel u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    task automatic send_item(bit tick, bit restart);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_DATA_BITS-2){1'b0}}, restart, tick};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(tick, restart);
    endtask

    // mostly ticks, with a few restarts and idle items mixed in
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            send_item(1'($urandom_range(0, 1)), 1'b1);
        else if (r < 14)
            send_item(1'b0, 1'b0);
        else
            send_item(1'b1, 1'b0);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic apb_read(logic [IDX_BITS-1:0] idx, output logic [DATA_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_write(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
        logic [DATA_BITS-1:0] rd;
        logic [DATA_BITS-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        if (idx <= REG_ENABLE) begin
            @(posedge aclk);
            apb_read(idx, rd);
            want = (idx == REG_ENABLE) ? (val & {{(DATA_BITS-CHANNELS){1'b0}}, {CHANNELS{1'b1}}})
                                       : (val & 32'h0000_ffff);
            if (rd !== want)
                sb.report_mismatch($sformatf("register %0d read %h, expected %h", idx, rd, want));
        end
        @(posedge aclk);
    endtask

    // program only when the block is idle
    task automatic configure(logic [15:0] pre, logic [15:0] p0, logic [15:0] p1,
                             logic [15:0] p2, logic [15:0] p3, logic [3:0] en);
        wait_results();
        repeat (LATENCY + 1) @(posedge aclk);
        apb_write(REG_PRESCALE, {16'h0, pre});
        apb_write(REG_PERIOD0,     {16'h0, p0});
        apb_write(IDX_BITS'(REG_PERIOD0 + 1), {16'h0, p1});
        apb_write(IDX_BITS'(REG_PERIOD0 + 2), {16'h0, p2});
        apb_write(IDX_BITS'(REG_PERIOD0 + 3), {16'h0, p3});
        apb_write(REG_ENABLE, {28'h0, en});
    endtask

    // receiver: random stalls, one long hold-off on request, check each item
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_LONG) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            gap = rx_idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: channels off, counter runs
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);

        // short periods, a zero period and the widest one
        configure(16'h0000, 16'd1, 16'd2, 16'd0, 16'hffff, 4'hf);
        send_item(1'b0, 1'b1);
        repeat (3) send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        repeat (2) send_item(1'b1, 1'b0);

        // largest prescale: ticks that do not advance
        configure(16'hffff, 16'd1, 16'd2, 16'd0, 16'hffff, 4'hf);
        repeat (3) send_item(1'b1, 1'b0);

        // lower the limit below the running prescale count
        configure(16'd2, 16'd3, 16'd3, 16'd3, 16'd3, 4'h5);
        repeat (4) send_item(1'b1, 1'b0);

        // writes past the last register are dropped
        wait_results();
        repeat (LATENCY + 1) @(posedge aclk);
        apb_write(REG_SPARE, 32'hffff_ffff);
        repeat (2) send_item(1'b1, 1'b0);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: configure(16'd0, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                             16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)), 4'hf);
                1: configure(16'($urandom_range(1, 3)), 16'($urandom_range(0, 16)),
                             16'($urandom_range(0, 16)), 16'($urandom_range(0, 16)),
                             16'($urandom_range(0, 16)), 4'($urandom_range(0, 15)));
                2: configure(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'h0);
                3: configure(16'd0, 16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                             16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)), 4'hf);
                4: configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'hf);
                6: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
                default: configure(16'($urandom_range(0, 4)), 16'($urandom_range(0, 40)),
                                   16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                   16'($urandom_range(0, 40)), 4'($urandom_range(0, 15)));
            endcase
            // keep the prescale count from the last phase where the limit drops
            if (p != 3) send_item(1'b0, 1'b1);
            for (int i = 0; i < 170; i++) begin
                if (p == 5 && i == 40) rx_hold_req = 1'b1;
                if (p == 5 && i == 120) wait_results();
                random_item();
            end
        end

        // back-to-back items at the sustained rate
        configure(16'd0, 16'd3, 16'd7, 16'd1, 16'd100, 4'hf);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_item(1'b0, 1'b1);
        repeat (150) send_item(1'b1, 1'b0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        wait_results();
        repeat (LATENCY + 4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== periodic_compare_timer_four_channel.f =====
rtl/core/pct_pkg.sv
rtl/core/pct_regs.sv
rtl/core/periodic_compare_timer_four_channel.sv
tb/tb.sv
